### hw/rtl/jms_pkg.sv
// Shared types and constants for the JTAG master shift engine.
// Holds the microcode word layout and the microprogram ROM.
// No dependencies.
package jms_pkg;

	localparam int DATA_W     = 64;
	localparam int ACT_W      = 3;
	localparam int BCNT_W     = 7;
	localparam int IRL_W      = 6;
	localparam int IR_LEN_MAX = 32;
	localparam int UPC_W      = 3;
	localparam int PAT_W      = 5;

	// Command codes carried in s_tuser
	localparam logic [ACT_W-1:0] ACT_RESET = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PATH  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SHIFT = 3'd2;
	localparam logic [ACT_W-1:0] ACT_IDLE  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_IR    = 3'd4;

	// Microprogram addresses; the first five equal the command codes
	localparam logic [UPC_W-1:0] UPC_RESET    = 3'd0;
	localparam logic [UPC_W-1:0] UPC_PATH     = 3'd1;
	localparam logic [UPC_W-1:0] UPC_SHIFT    = 3'd2;
	localparam logic [UPC_W-1:0] UPC_IDLE     = 3'd3;
	localparam logic [UPC_W-1:0] UPC_IR_RST   = 3'd4;
	localparam logic [UPC_W-1:0] UPC_IR_PATH  = 3'd5;
	localparam logic [UPC_W-1:0] UPC_IR_SHIFT = 3'd6;

	// TMS source select
	localparam logic [2:0] TMS_ONE      = 3'd0;
	localparam logic [2:0] TMS_DATA     = 3'd1;
	localparam logic [2:0] TMS_PAT      = 3'd2;
	localparam logic [2:0] TMS_FTMS     = 3'd3;
	localparam logic [2:0] TMS_LAST_F   = 3'd4;
	localparam logic [2:0] TMS_LAST_ONE = 3'd5;

	// Tick count source select
	localparam logic [1:0] CNT_FIVE = 2'd0;
	localparam logic [1:0] CNT_BITS = 2'd1;
	localparam logic [1:0] CNT_IRL  = 2'd2;

	localparam logic [PAT_W-1:0] IR_PATH_PATTERN = 5'b00110;
	localparam logic [IRL_W-1:0] IRL_RESET       = 6'd10;

	typedef struct packed {
		logic [2:0]       tms_sel;
		logic             tdi_data;
		logic             use_data;
		logic             use_pat;
		logic             cap;
		logic [1:0]       cnt_sel;
		logic             is_end;
		logic [UPC_W-1:0] next_upc;
	} ucw_t;

	typedef struct packed {
		logic load;
		logic tick;
		logic seg_last;
		logic last;
		ucw_t cw;
	} ctl_t;

	function automatic ucw_t jms_rom(input logic [UPC_W-1:0] upc);
		ucw_t w;
		w = '0;
		w.is_end = 1'b1;
		case (upc)
			UPC_RESET: begin
				w.tms_sel = TMS_ONE;
				w.cnt_sel = CNT_FIVE;
			end
			UPC_PATH: begin
				w.tms_sel  = TMS_DATA;
				w.use_data = 1'b1;
				w.cnt_sel  = CNT_BITS;
			end
			UPC_SHIFT: begin
				w.tms_sel  = TMS_LAST_F;
				w.tdi_data = 1'b1;
				w.use_data = 1'b1;
				w.cap      = 1'b1;
				w.cnt_sel  = CNT_BITS;
			end
			UPC_IDLE: begin
				w.tms_sel = TMS_FTMS;
				w.cnt_sel = CNT_BITS;
			end
			UPC_IR_RST: begin
				w.tms_sel  = TMS_ONE;
				w.cnt_sel  = CNT_FIVE;
				w.is_end   = 1'b0;
				w.next_upc = UPC_IR_PATH;
			end
			UPC_IR_PATH: begin
				w.tms_sel  = TMS_PAT;
				w.use_pat  = 1'b1;
				w.cnt_sel  = CNT_FIVE;
				w.is_end   = 1'b0;
				w.next_upc = UPC_IR_SHIFT;
			end
			UPC_IR_SHIFT: begin
				w.tms_sel  = TMS_LAST_ONE;
				w.tdi_data = 1'b1;
				w.use_data = 1'b1;
				w.cap      = 1'b1;
				w.cnt_sel  = CNT_IRL;
			end
			default: begin
				w.tms_sel = TMS_ONE;
			end
		endcase
		return w;
	endfunction

endpackage

### hw/rtl/jms_cfg.sv
// APB-style register file for the JTAG master shift engine.
// Holds ir_length. Depends on jms_pkg.
module jms_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output logic [jms_pkg::IRL_W-1:0] ir_length
);

	logic [jms_pkg::IRL_W-1:0] ir_length_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_length_q <= jms_pkg::IRL_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			ir_length_q <= pwdata[jms_pkg::IRL_W-1:0];
		end
	end

	assign prdata    = (paddr[2] == 1'b0) ? {{(32-jms_pkg::IRL_W){1'b0}}, ir_length_q} : 32'd0;
	assign ir_length = ir_length_q;

endmodule

### hw/rtl/jms_sequencer.sv
// Microprogram sequencer: program counter, tick counter and step jumps.
// Reads control words from the ROM in jms_pkg.
module jms_sequencer #(
	parameter int MAX_SHIFT_BITS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [jms_pkg::ACT_W-1:0]  action,
	input  logic [jms_pkg::BCNT_W-1:0] bit_count,
	input  logic [jms_pkg::IRL_W-1:0]  ir_length,
	input  logic                       out_free,
	output jms_pkg::ctl_t              ctl
);

	localparam int CNT_MAX = (MAX_SHIFT_BITS > jms_pkg::IR_LEN_MAX) ?
		MAX_SHIFT_BITS : jms_pkg::IR_LEN_MAX;
	localparam int CNT_W = $clog2(CNT_MAX + 1);

	logic                      busy_q;
	logic [jms_pkg::UPC_W-1:0] upc_q;
	logic [CNT_W-1:0]          rem_q;

	logic [CNT_W-1:0]    bits_sat;
	logic [CNT_W-1:0]    irl_clamp;
	logic [CNT_W-1:0]    entry_cnt;
	logic [CNT_W-1:0]    next_cnt;
	jms_pkg::ucw_t       cw;
	jms_pkg::ucw_t       entry_cw;
	jms_pkg::ucw_t       next_cw;
	logic                take;
	logic                start;
	logic                tick;
	logic                seg_last;

	function automatic logic [CNT_W-1:0] cnt_of(input logic [1:0] sel,
			input logic [CNT_W-1:0] bits, input logic [CNT_W-1:0] irl);
		logic [CNT_W-1:0] c;
		case (sel)
			jms_pkg::CNT_FIVE: c = CNT_W'(5);
			jms_pkg::CNT_BITS: c = bits;
			jms_pkg::CNT_IRL:  c = irl;
			default:           c = CNT_W'(5);
		endcase
		return c;
	endfunction

	always_comb begin
		if (bit_count > jms_pkg::BCNT_W'(MAX_SHIFT_BITS)) begin
			bits_sat = CNT_W'(MAX_SHIFT_BITS);
		end else begin
			bits_sat = CNT_W'(bit_count);
		end
		if (ir_length == '0) begin
			irl_clamp = CNT_W'(1);
		end else if (ir_length > jms_pkg::IRL_W'(jms_pkg::IR_LEN_MAX)) begin
			irl_clamp = CNT_W'(jms_pkg::IR_LEN_MAX);
		end else begin
			irl_clamp = CNT_W'(ir_length);
		end
	end

	assign cw        = jms_pkg::jms_rom(upc_q);
	assign entry_cw  = jms_pkg::jms_rom(action);
	assign next_cw   = jms_pkg::jms_rom(cw.next_upc);
	assign entry_cnt = cnt_of(entry_cw.cnt_sel, bits_sat, irl_clamp);
	assign next_cnt  = cnt_of(next_cw.cnt_sel, bits_sat, irl_clamp);

	assign s_tready = !busy_q;
	assign take     = s_tvalid && s_tready;
	// drop unknown commands and empty counts
	assign start    = take && (action <= jms_pkg::ACT_IR) && (entry_cnt != '0);
	assign tick     = busy_q && out_free;
	assign seg_last = (rem_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= jms_pkg::UPC_RESET;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			upc_q  <= action;
			rem_q  <= entry_cnt;
		end else if (tick) begin
			if (seg_last) begin
				if (cw.is_end) begin
					busy_q <= 1'b0;
				end else begin
					upc_q <= cw.next_upc;
					rem_q <= next_cnt;
				end
			end else begin
				rem_q <= rem_q - CNT_W'(1);
			end
		end
	end

	always_comb begin
		ctl.load     = take;
		ctl.tick     = tick;
		ctl.seg_last = seg_last;
		ctl.last     = seg_last && cw.is_end;
		ctl.cw       = cw;
	end

endmodule

### hw/rtl/jms_datapath.sv
// Shift datapath: TDI/pattern shifters, TDO capture mask, output word register.
// Driven by control words from jms_sequencer. Depends on jms_pkg.
module jms_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  jms_pkg::ctl_t              ctl,
	input  logic [jms_pkg::DATA_W-1:0] data_out,
	input  logic                       final_tms,
	input  logic [jms_pkg::DATA_W-1:0] tdo_bits,
	output logic                       out_free,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic                       tms_level,
	output logic                       tdi_level,
	output logic                       last_tick,
	output logic [jms_pkg::DATA_W-1:0] captured
);

	logic [jms_pkg::DATA_W-1:0] data_q;
	logic [jms_pkg::DATA_W-1:0] tdo_q;
	logic [jms_pkg::DATA_W-1:0] mask_q;
	logic [jms_pkg::PAT_W-1:0]  pat_q;
	logic                       ftms_q;

	logic                       out_valid_q;
	logic                       tms_q;
	logic                       tdi_q;
	logic                       last_q;
	logic [jms_pkg::DATA_W-1:0] cap_q;

	logic                       tms_nxt;
	logic                       tdi_nxt;
	logic [jms_pkg::DATA_W-1:0] mask_nxt;

	assign mask_nxt = {mask_q[jms_pkg::DATA_W-2:0], 1'b1};

	always_comb begin
		case (ctl.cw.tms_sel)
			jms_pkg::TMS_ONE:      tms_nxt = 1'b1;
			jms_pkg::TMS_DATA:     tms_nxt = data_q[0];
			jms_pkg::TMS_PAT:      tms_nxt = pat_q[0];
			jms_pkg::TMS_FTMS:     tms_nxt = ftms_q;
			jms_pkg::TMS_LAST_F:   tms_nxt = ctl.seg_last && ftms_q;
			jms_pkg::TMS_LAST_ONE: tms_nxt = ctl.seg_last;
			default:               tms_nxt = 1'b0;
		endcase
		tdi_nxt = ctl.cw.tdi_data && data_q[0];
	end

	// operand registers: load on accept, advance one bit per tick
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= data_out;
			tdo_q  <= tdo_bits;
			ftms_q <= final_tms;
			pat_q  <= jms_pkg::IR_PATH_PATTERN;
			mask_q <= '0;
		end else if (ctl.tick) begin
			if (ctl.cw.use_data) begin
				data_q <= {1'b0, data_q[jms_pkg::DATA_W-1:1]};
			end
			if (ctl.cw.use_pat) begin
				pat_q <= {1'b0, pat_q[jms_pkg::PAT_W-1:1]};
			end
			if (ctl.cw.cap) begin
				mask_q <= mask_nxt;
			end
		end
	end

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.tick) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.tick) begin
			tms_q  <= tms_nxt;
			tdi_q  <= tdi_nxt;
			last_q <= ctl.last;
			cap_q  <= (ctl.last && ctl.cw.cap) ? (tdo_q & mask_nxt) : '0;
		end
	end

	assign m_tvalid  = out_valid_q;
	assign tms_level = tms_q;
	assign tdi_level = tdi_q;
	assign last_tick = last_q;
	assign captured  = cap_q;

endmodule

### hw/rtl/jtag_master_shift_engine_core.sv
// Top level of the JTAG master shift engine.
// Instantiates jms_cfg, jms_sequencer and jms_datapath; depends on jms_pkg.
//
//  port group  | dir | word                                   | accepted when
//  s_*         | in  | tuser=action, tdata=command operands   | s_tvalid && s_tready
//  m_*         | out | tdata=tms,tdi,captured; tlast=last tick| m_tvalid && m_tready
//  APB         | in  | ir_length at byte address 0            | psel&&penable&&pwrite
//
// A command is accepted only while idle and then runs as TCK ticks: 5 for reset,
// bit_count (1..MAX_SHIFT_BITS) for path, shift and idle, 10 + ir_length (held to
// 1..32) for an instruction shift. The single tick counter of the sequencer sets this.
// A low m_tready freezes the sequencer with the pending word held in the output
// register. Reset leaves ir_length at 10 and the engine idle; no clearing pass.
module jtag_master_shift_engine_core #(
	parameter int MAX_SHIFT_BITS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [6:0] bit_count, [70:7] data_out, [71] final_tms, [135:72] tdo_bits
	input  logic [135:0] s_tdata,
	// [2:0] action
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] tms_level, [1] tdi_level, [65:2] captured, [71:66] zero
	output logic [71:0]  m_tdata,
	output logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [jms_pkg::IRL_W-1:0]  ir_length;
	logic                       out_free;
	jms_pkg::ctl_t              ctl;
	logic                       tms_level;
	logic                       tdi_level;
	logic [jms_pkg::DATA_W-1:0] captured;

	jms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.ir_length (ir_length)
	);

	jms_sequencer #(
		.MAX_SHIFT_BITS (MAX_SHIFT_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.action    (s_tuser),
		.bit_count (s_tdata[6:0]),
		.ir_length (ir_length),
		.out_free  (out_free),
		.ctl       (ctl)
	);

	jms_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.data_out  (s_tdata[70:7]),
		.final_tms (s_tdata[71]),
		.tdo_bits  (s_tdata[135:72]),
		.out_free  (out_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.tms_level (tms_level),
		.tdi_level (tdi_level),
		.last_tick (m_tlast),
		.captured  (captured)
	);

	assign m_tdata = {6'd0, captured, tdi_level, tms_level};

endmodule
